// ===== hw/rtl/xbt_pkg.sv =====
`timescale 1ns / 1ps

package xbt_pkg;

  localparam int KEY_BITS   = 10;
  localparam int COUNT_BITS = 16;

  // trie nodes in heap order: root is node 1, leaf of s is 2^KEY_BITS + s
  localparam int NODE_BITS  = KEY_BITS + 1;
  localparam int NODE_COUNT = 2 ** NODE_BITS;
  localparam int LVL_BITS   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  // compare width wide enough for both the 16-bit ports and the counters
  localparam int ARG_BITS   = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // port field widths
  localparam int OP_W     = 3;
  localparam int KEY_W    = 10;
  localparam int AMOUNT_W = 16;
  localparam int RANK_W   = 16;
  localparam int VALUE_W  = 10;
  localparam int LEAFC_W  = 16;
  localparam int TOTAL_W  = 16;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd2;
  localparam logic [OP_W-1:0] OP_KTH    = 3'd3;
  localparam logic [OP_W-1:0] OP_MIN    = 3'd4;
  localparam logic [OP_W-1:0] OP_MAX    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF   = 2'd2;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [LEAFC_W-1:0]  leaf_count;
    logic [TOTAL_W-1:0]  total;
    logic [STATUS_W-1:0] status;
  } xbt_result_t;

endpackage

// ===== hw/rtl/xor_binary_trie_multiset_top.sv =====
`timescale 1ns / 1ps

// Multiset of keys kept as a binary trie of prefix counters in one counter
// RAM (one read, one write per cycle, registered read data). One operation
// is taken at a time. Insert and erase read the leaf on the accepting cycle,
// then one counter per level is read, modified and written back on the way
// to the root. Kth, min and max make one dependent counter read per level
// on the way down. Count and a rejected insert only read the leaf counter;
// errors and unused codes go straight to the output. A finished result sits
// in an output register, so the next operation can start while it waits.
// After reset the counter RAM is swept to zero with the input stalled.

module xor_binary_trie_multiset_top
  import xbt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [AMOUNT_W-1:0] amount_i,
  input  logic [KEY_W-1:0]    xor_mask_i,
  input  logic [RANK_W-1:0]   rank_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VALUE_W-1:0]  value_o,
  output logic [LEAFC_W-1:0]  leaf_count_o,
  output logic [TOTAL_W-1:0]  total_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_SEL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [NODE_BITS-1:0] ROOT = NODE_BITS'(1);

  logic [2:0]            state_q, state_d;
  logic [NODE_BITS-1:0]  clr_q, clr_d;
  logic [NODE_BITS-1:0]  node_q, node_d;
  logic [LVL_BITS-1:0]   lvl_q, lvl_d;
  logic                  first_q, first_d;
  logic                  sub_q, sub_d;
  logic [COUNT_BITS-1:0] n_q, n_d;
  logic [COUNT_BITS-1:0] rank_q, rank_d;
  logic [KEY_BITS-1:0]   mask_q, mask_d;
  logic [ARG_BITS-1:0]   amount_q, amount_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [KEY_BITS-1:0]   value_q, value_d;
  logic [COUNT_BITS-1:0] leafc_q, leafc_d;
  logic [STATUS_W-1:0]   status_q, status_d;

  // counter RAM
  logic [COUNT_BITS-1:0] cnt_mem [NODE_COUNT];
  logic                  mem_we;
  logic [NODE_BITS-1:0]  mem_wa, mem_ra;
  logic [COUNT_BITS-1:0] mem_wd;
  logic [COUNT_BITS-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= mem_wd;
    end
    rd_q <= cnt_mem[mem_ra];
  end

  logic                  in_xfer;
  logic                  buf_ready;
  logic                  out_load;
  xbt_result_t           result;

  logic [KEY_BITS-1:0]   key_k, mask_k, s_k;
  logic [NODE_BITS-1:0]  leaf_node, sel_first;
  logic [ARG_BITS-1:0]   amount_w, rank_w, total_w;
  logic                  ovf;
  logic [COUNT_BITS-1:0] n_first, n_eff, upd_wd;
  logic [NODE_BITS-1:0]  node_up, node_n;
  logic                  take, b_sel;
  logic [LVL_BITS-1:0]   lvl_dn;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign key_k     = KEY_BITS'(key_i);
  assign mask_k    = KEY_BITS'(xor_mask_i);
  assign s_k       = key_k ^ mask_k;
  assign leaf_node = {1'b1, s_k};
  assign sel_first = NODE_BITS'(2) | NODE_BITS'(mask_k[KEY_BITS-1]);

  assign amount_w = ARG_BITS'(amount_i);
  assign rank_w   = ARG_BITS'(rank_i);
  assign total_w  = ARG_BITS'(total_q);
  assign ovf      = ({1'b0, total_w} + {1'b0, amount_w}) > {1'b0, ARG_BITS'(COUNT_MAX)};

  // update walk: erase clips to the leaf count seen on the first level
  assign n_first = !sub_q ? COUNT_BITS'(amount_q)
                 : ((amount_q < ARG_BITS'(rd_q)) ? COUNT_BITS'(amount_q) : rd_q);
  assign n_eff   = first_q ? n_first : n_q;
  assign upd_wd  = sub_q ? (rd_q - n_eff) : (rd_q + n_eff);
  assign node_up = node_q >> 1;

  // select walk: go to the mask side unless its count does not exceed rank
  assign take   = (rd_q <= rank_q);
  assign b_sel  = mask_q[lvl_q] ^ take;
  assign node_n = {node_q[NODE_BITS-2:0], b_sel};
  assign lvl_dn = LVL_BITS'(lvl_q - 1'b1);

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    node_d   = node_q;
    lvl_d    = lvl_q;
    first_d  = first_q;
    sub_d    = sub_q;
    n_d      = n_q;
    rank_d   = rank_q;
    mask_d   = mask_q;
    amount_d = amount_q;
    total_d  = total_q;
    value_d  = value_q;
    leafc_d  = leafc_q;
    status_d = status_q;
    mem_we   = 1'b0;
    mem_wa   = node_q;
    mem_wd   = '0;
    mem_ra   = node_q;
    out_load = 1'b0;

    unique case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        mem_ra = leaf_node;
        if (operation_i == OP_KTH || operation_i == OP_MIN || operation_i == OP_MAX) begin
          mem_ra = sel_first;
        end
        if (in_xfer) begin
          mask_d   = mask_k;
          amount_d = amount_w;
          value_d  = '0;
          leafc_d  = '0;
          status_d = ST_OK;
          first_d  = 1'b1;
          case (operation_i) inside
            OP_INSERT: begin
              if (ovf) begin
                status_d = ST_OVF;
                state_d  = S_RD;
              end else begin
                sub_d   = 1'b0;
                node_d  = leaf_node;
                state_d = S_UPD;
              end
            end
            OP_ERASE: begin
              sub_d   = 1'b1;
              node_d  = leaf_node;
              state_d = S_UPD;
            end
            OP_COUNT: begin
              state_d = S_RD;
            end
            OP_KTH, OP_MIN, OP_MAX: begin
              if (total_q == '0 || (operation_i == OP_KTH && rank_w >= total_w)) begin
                status_d = ST_EMPTY;
                state_d  = S_OUT;
              end else begin
                if (operation_i == OP_KTH) begin
                  rank_d = COUNT_BITS'(rank_i);
                end else if (operation_i == OP_MIN) begin
                  rank_d = '0;
                end else begin
                  rank_d = total_q - 1'b1;
                end
                node_d  = ROOT;
                lvl_d   = LVL_BITS'(KEY_BITS - 1);
                state_d = S_SEL;
              end
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end

      S_RD: begin
        leafc_d = rd_q;
        state_d = S_OUT;
      end

      S_UPD: begin
        mem_we = 1'b1;
        mem_wa = node_q;
        mem_wd = upd_wd;
        if (first_q) begin
          leafc_d = upd_wd;
          n_d     = n_eff;
          first_d = 1'b0;
        end
        // the root lives in total_q, the walk stops below it
        if (node_up == ROOT) begin
          total_d = sub_q ? (total_q - n_eff) : (total_q + n_eff);
          state_d = S_OUT;
        end else begin
          mem_ra = node_up;
          node_d = node_up;
        end
      end

      S_SEL: begin
        rank_d = take ? (rank_q - rd_q) : rank_q;
        node_d = node_n;
        if (lvl_q == '0) begin
          value_d = node_n[KEY_BITS-1:0] ^ mask_q;
          state_d = S_OUT;
        end else begin
          lvl_d  = lvl_dn;
          mem_ra = {node_n[NODE_BITS-2:0], mask_q[lvl_dn]};
        end
      end

      S_OUT: begin
        if (buf_ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      total_q <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      total_q <= total_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q   <= node_d;
    lvl_q    <= lvl_d;
    sub_q    <= sub_d;
    n_q      <= n_d;
    rank_q   <= rank_d;
    mask_q   <= mask_d;
    amount_q <= amount_d;
    value_q  <= value_d;
    leafc_q  <= leafc_d;
    status_q <= status_d;
  end

  assign result.value      = VALUE_W'(value_q);
  assign result.leaf_count = LEAFC_W'(leafc_q);
  assign result.total      = TOTAL_W'(total_q);
  assign result.status     = status_q;

  xbt_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (out_load),
    .data_i       (result),
    .ready_o      (buf_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o),
    .leaf_count_o (leaf_count_o),
    .total_o      (total_o),
    .status_o     (status_o)
  );

  // erase never takes a counter below zero
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && sub_q) |-> (rd_q >= n_eff))
    else $error("erase underflows a prefix counter");

  // insert passed the total check, so no counter on the path can wrap
  a_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && !sub_q) |->
      (({1'b0, rd_q} + {1'b0, n_eff}) <= {1'b0, COUNT_MAX}))
    else $error("insert wraps a prefix counter");

  // the update walk stops below the root
  a_root_untouched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == S_UPD) |-> (mem_wa != ROOT))
    else $error("update walk wrote the root node");

  // the total only moves at the end of an update walk
  a_total_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_UPD && state_q != S_CLR) |=> (total_q == $past(total_q)))
    else $error("total changed outside an update");

endmodule

// ===== hw/rtl/xbt_out_buf.sv =====
`timescale 1ns / 1ps

module xbt_out_buf
  import xbt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  xbt_result_t         data_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VALUE_W-1:0]  value_o,
  output logic [LEAFC_W-1:0]  leaf_count_o,
  output logic [TOTAL_W-1:0]  total_o,
  output logic [STATUS_W-1:0] status_o
);

  logic        valid_q, valid_d;
  xbt_result_t data_q;

  // slot frees up in the same cycle its transfer completes
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i && ready_o) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign value_o      = data_q.value;
  assign leaf_count_o = data_q.leaf_count;
  assign total_o      = data_q.total;
  assign status_o     = data_q.status;

endmodule

// ===== bench/xbt_trie_checker.sv =====
`timescale 1ns / 1ps

module xbt_trie_checker
  import xbt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [KEY_W-1:0]      key_i,
  input  logic [AMOUNT_W-1:0]   amount_i,
  input  logic [KEY_W-1:0]      xor_mask_i,
  input  logic [RANK_W-1:0]     rank_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [VALUE_W-1:0]    value_i,
  input  logic [LEAFC_W-1:0]    leaf_count_i,
  input  logic [TOTAL_W-1:0]    total_i,
  input  logic [STATUS_W-1:0]   status_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    empty_o,
  output int                    ovf_o,
  output logic [COUNT_BITS-1:0] trie_total_o
);

  localparam int LEAF_BASE = 2 ** KEY_BITS;

  // shadow copy of the prefix counters, heap order, node 0 unused
  logic [COUNT_BITS-1:0] trie_cnt [NODE_COUNT];
  xbt_result_t           outcomes_q [$];
  xbt_result_t           oldest;
  int                    fails;
  int                    checked;
  int                    n_empty;
  int                    n_ovf;

  function automatic void walk_path(int leaf, logic [COUNT_BITS-1:0] n, bit sub);
    int node;
    node = leaf;
    while (node != 0) begin
      trie_cnt[node] = sub ? trie_cnt[node] - n : trie_cnt[node] + n;
      node = node >> 1;
    end
  endfunction

  // descend from the root toward the pos-th smallest of s ^ mask
  function automatic logic [KEY_BITS-1:0] pick_ordered(logic [COUNT_BITS-1:0] pos,
                                                       logic [KEY_BITS-1:0] mask);
    int                    node;
    logic                  b;
    logic [COUNT_BITS-1:0] c;
    logic [KEY_BITS-1:0]   s;
    node = 1;
    s    = '0;
    for (int i = KEY_BITS - 1; i >= 0; i--) begin
      b = mask[i];
      c = trie_cnt[2 * node + int'(b)];
      if (c <= pos) begin
        pos = pos - c;
        b   = ~b;
      end
      node = 2 * node + int'(b);
      s[i] = b;
    end
    return s ^ mask;
  endfunction

  function automatic xbt_result_t apply_trie_op(logic [OP_W-1:0]     op,
                                                logic [KEY_W-1:0]    key,
                                                logic [AMOUNT_W-1:0] amount,
                                                logic [KEY_W-1:0]    mask,
                                                logic [RANK_W-1:0]   rank);
    xbt_result_t           r;
    logic [KEY_BITS-1:0]   s;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] take;
    logic [COUNT_BITS-1:0] pos;
    int                    leaf;
    r    = '0;
    s    = key[KEY_BITS-1:0] ^ mask[KEY_BITS-1:0];
    leaf = LEAF_BASE + int'(s);
    case (op)
      OP_INSERT: begin
        sum = {1'b0, trie_cnt[1]} + {1'b0, amount};
        if (sum > {1'b0, COUNT_MAX}) r.status = ST_OVF;
        else walk_path(leaf, amount, 1'b0);
        r.leaf_count = trie_cnt[leaf];
      end
      OP_ERASE: begin
        take = (amount < trie_cnt[leaf]) ? amount : trie_cnt[leaf];
        walk_path(leaf, take, 1'b1);
        r.leaf_count = trie_cnt[leaf];
      end
      OP_COUNT: r.leaf_count = trie_cnt[leaf];
      OP_KTH, OP_MIN, OP_MAX: begin
        if (trie_cnt[1] == 0 || (op == OP_KTH && rank >= trie_cnt[1])) begin
          r.status = ST_EMPTY;
        end else begin
          if (op == OP_KTH) pos = rank;
          else if (op == OP_MIN) pos = '0;
          else pos = trie_cnt[1] - 1'b1;
          r.value = pick_ordered(pos, mask[KEY_BITS-1:0]);
        end
      end
      default: ;
    endcase
    r.total = trie_cnt[1];
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NODE_COUNT; n++) trie_cnt[n] = '0;
      outcomes_q.delete();
    end else begin
      // a result always trails its own transfer, so drain before predicting
      if (out_valid_i && !out_stall_i) begin
        if (outcomes_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got value %0d count %0d",
                   $time, value_i, leaf_count_i);
          $display("%0t: unexpected result total %0d status %0d",
                   $time, total_i, status_i);
        end else begin
          oldest = outcomes_q.pop_front();
          check_field("value", 32'(oldest.value), 32'(value_i));
          check_field("leaf_count", 32'(oldest.leaf_count), 32'(leaf_count_i));
          check_field("total", 32'(oldest.total), 32'(total_i));
          check_field("status", 32'(oldest.status), 32'(status_i));
          checked++;
          if (status_i == ST_EMPTY) n_empty++;
          if (status_i == ST_OVF) n_ovf++;
        end
      end
      if (in_valid_i && !in_stall_i)
        outcomes_q.push_back(apply_trie_op(operation_i, key_i, amount_i, xor_mask_i, rank_i));
    end
    fail_count_o <= fails;
    pending_o    <= outcomes_q.size();
    checked_o    <= checked;
    empty_o      <= n_empty;
    ovf_o        <= n_ovf;
    trie_total_o <= trie_cnt[1];
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import xbt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam int QUIET_LIMIT  = 20000;
  localparam int PER_PHASE    = 475;
  localparam int TAIL_CYCLES  = 30;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [OP_W-1:0]       operation_i  = '0;
  logic [KEY_W-1:0]      key_i        = '0;
  logic [AMOUNT_W-1:0]   amount_i     = '0;
  logic [KEY_W-1:0]      xor_mask_i   = '0;
  logic [RANK_W-1:0]     rank_i       = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [VALUE_W-1:0]    value_o;
  logic [LEAFC_W-1:0]    leaf_count_o;
  logic [TOTAL_W-1:0]    total_o;
  logic [STATUS_W-1:0]   status_o;

  int                    fail_count;
  int                    pending;
  int                    checked;
  int                    n_empty;
  int                    n_ovf;
  logic [COUNT_BITS-1:0] model_total;

  int                    idle_pct  = 0;
  int                    stall_pct = 0;
  int                    quiet     = 0;
  int                    n_sent    = 0;
  int                    n_directed;
  logic [KEY_W-1:0]      key_pool [16];

  xor_binary_trie_multiset_top uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .key_i, .amount_i,
    .xor_mask_i, .rank_i, .out_valid_o, .out_stall_i, .value_o, .leaf_count_o,
    .total_o, .status_o
  );

  xbt_trie_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .key_i,
    .amount_i, .xor_mask_i, .rank_i, .out_valid_i(out_valid_o), .out_stall_i,
    .value_i(value_o), .leaf_count_i(leaf_count_o), .total_i(total_o),
    .status_i(status_o), .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked), .empty_o(n_empty), .ovf_o(n_ovf), .trie_total_o(model_total)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // no transfer on either side for too long means a hang
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // returns at the edge where the transfer happened
  task automatic send_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                           logic [AMOUNT_W-1:0] amount, logic [KEY_W-1:0] mask,
                           logic [RANK_W-1:0] rank);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_i       <= key;
    amount_i    <= amount;
    xor_mask_i  <= mask;
    rank_i      <= rank;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic send_random(logic [KEY_W-1:0] base_mask, output bit useful);
    int                  roll;
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    key;
    logic [KEY_W-1:0]    mask;
    logic [AMOUNT_W-1:0] amount;
    logic [RANK_W-1:0]   rank;
    roll = $urandom_range(99);
    if (roll < 30) op = OP_INSERT;
    else if (roll < 50) op = OP_ERASE;
    else if (roll < 62) op = OP_COUNT;
    else if (roll < 82) op = OP_KTH;
    else if (roll < 89) op = OP_MIN;
    else if (roll < 96) op = OP_MAX;
    else op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    key  = ($urandom_range(99) < 80) ? key_pool[4'($urandom_range(15))]
                                     : KEY_W'($urandom);
    mask = ($urandom_range(1) != 0) ? base_mask : KEY_W'($urandom);
    roll = $urandom_range(99);
    if (roll < 70) amount = AMOUNT_W'($urandom_range(12, 1));
    else if (roll < 80) amount = AMOUNT_W'($urandom_range(300));
    else if (roll < 95) amount = AMOUNT_W'($urandom);
    else amount = '1;
    // ranks mostly near the live total so kth lands inside the set
    if ($urandom_range(99) < 80) rank = RANK_W'($urandom_range(int'(model_total) + 1));
    else rank = RANK_W'($urandom);
    useful = (op <= OP_MAX);
    send_item(op, key, amount, mask, rank);
  endtask

  initial begin
    bit               useful;
    int               done;
    logic [KEY_W-1:0] base_mask;
    wait (rst_ni);
    @(posedge clk_i);

    // empty set, absent keys, order under masks, clamped erase, overflow at the top
    send_item(OP_MIN,   10'h000, 16'h0000, 10'h3FF, 16'h0000);
    send_item(OP_MAX,   10'h3FF, 16'hFFFF, 10'h000, 16'hFFFF);
    send_item(OP_KTH,   10'h000, 16'h0000, 10'h000, 16'h0000);
    send_item(OP_COUNT, 10'h3FF, 16'h0000, 10'h000, 16'h0000);
    send_item(OP_ERASE, 10'h005, 16'h0003, 10'h000, 16'h0000);
    send_item(OP_INSERT, 10'h3FF, 16'h0001, 10'h000, 16'h0000);
    send_item(OP_INSERT, 10'h000, 16'h0002, 10'h3FF, 16'h0000);
    send_item(OP_INSERT, 10'h000, 16'h0004, 10'h000, 16'h0000);
    send_item(OP_INSERT, 10'h155, 16'h0000, 10'h2AA, 16'h0000);
    send_item(OP_KTH,   10'h000, 16'h0000, 10'h3FF, 16'h0000);
    send_item(OP_KTH,   10'h000, 16'h0000, 10'h000, 16'h0006);
    send_item(OP_KTH,   10'h000, 16'h0000, 10'h000, 16'h0007);
    send_item(OP_MIN,   10'h000, 16'h0000, 10'h155, 16'h0000);
    send_item(OP_MAX,   10'h000, 16'h0000, 10'h2AA, 16'h0000);
    send_item(OP_ERASE, 10'h000, 16'hFFFF, 10'h000, 16'h0000);
    send_item(OP_INSERT, 10'h200, 16'hFFFF, 10'h1FF, 16'h0000);
    send_item(OP_INSERT, 10'h123, 16'hFFFC, 10'h000, 16'h0000);
    send_item(OP_INSERT, 10'h001, 16'h0001, 10'h000, 16'h0000);
    send_item(OP_INSERT, 10'h001, 16'h0000, 10'h000, 16'h0000);
    send_item(OP_KTH,   10'h000, 16'h0000, 10'h3FF, 16'hFFFE);
    send_item(OP_KTH,   10'h000, 16'h0000, 10'h3FF, 16'hFFFF);
    send_item(OP_UNUSED_LO, 10'h000, 16'h0000, 10'h000, 16'h0000);
    send_item(OP_UNUSED_HI, 10'h3FF, 16'hFFFF, 10'h3FF, 16'hFFFF);
    send_item(OP_ERASE, 10'h123, 16'hFFFF, 10'h000, 16'h0000);
    send_item(OP_ERASE, 10'h3FF, 16'hFFFF, 10'h000, 16'h0000);
    n_directed = n_sent;
    // sender holds off until every outstanding result is back
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      foreach (key_pool[k]) key_pool[k] = KEY_W'($urandom);
      base_mask = KEY_W'($urandom);
      done = 0;
      while (done < PER_PHASE) begin
        send_random(base_mask, useful);
        if (useful) done++;
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d operations (%0d directed) across four sender/receiver idle mixes.",
             n_sent, n_directed);
    $display("Checked %0d results: %0d empty or rank errors, %0d overflow rejects.",
             checked, n_empty, n_ovf);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/xbt_pkg.sv
hw/rtl/xbt_out_buf.sv
hw/rtl/xor_binary_trie_multiset_top.sv
bench/xbt_trie_checker.sv
bench/tb.sv
